// ===== rtl/coap_header_parser_core_defines.svh =====
// Assertion macros used by the CoAP header parser core.
`ifndef COAP_HEADER_PARSER_CORE_DEFINES_SVH
`define COAP_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define COAP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("coap header parser: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define COAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("coap header parser: next-cycle check failed");

`endif

// ===== rtl/coap_hdr_pkg.sv =====
// Types and constants for the CoAP header parser.
`timescale 1ns / 1ps
package coap_hdr_pkg;

	// Protocol constants
	localparam logic [1:0]  COAP_VERSION = 2'd1;
	localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
	localparam logic [15:0] HDR_LEN = 16'd4;
	localparam logic [15:0] TOK_MAX_LEN = 16'd8;

	// One input word: a datagram byte and its end flag
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} coap_in_t;

	// One result word, produced per datagram
	typedef struct packed {
		logic        ok;
		logic [1:0]  msg_type;
		logic [7:0]  code;
		logic [15:0] msg_id;
		logic [3:0]  token_count;
		logic [63:0] token_bytes;
		logic        payload_found;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} coap_out_t;

endpackage

// ===== rtl/coap_hdr_track.sv =====
// Per-datagram header capture state and result formation.
`timescale 1ns / 1ps
module coap_hdr_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  coap_hdr_pkg::coap_in_t word,
	output coap_hdr_pkg::coap_out_t res
);
	import coap_hdr_pkg::*;

	logic [15:0] cnt_q, cnt_d;
	logic [1:0]  type_q, type_d;
	logic [7:0]  code_q, code_d;
	logic [15:0] mid_q, mid_d;
	logic [3:0]  tlen_q, tlen_d;
	logic [63:0] tok_q, tok_d;
	logic        mark_q, mark_d;
	logic [15:0] pstart_q, pstart_d;
	logic        bad_q, bad_d;

	logic [15:0] hdr_end;
	logic [15:0] tok_idx;
	logic [15:0] need_len;
	logic [15:0] plen;
	logic        ok;

	// Capture by byte position, marker scan, saturating count
	always_comb begin
		cnt_d    = cnt_q;
		type_d   = type_q;
		code_d   = code_q;
		mid_d    = mid_q;
		tlen_d   = tlen_q;
		tok_d    = tok_q;
		mark_d   = mark_q;
		pstart_d = pstart_q;
		bad_d    = bad_q;
		hdr_end  = {12'd0, tlen_q} + HDR_LEN;
		tok_idx  = cnt_q - HDR_LEN;

		if (cnt_q == 16'd0) begin
			type_d = word.data_byte[5:4];
			tlen_d = word.data_byte[3:0];
			if ((word.data_byte[7:6] != COAP_VERSION) ||
				({12'd0, word.data_byte[3:0]} > TOK_MAX_LEN)) begin
				bad_d = 1'b1;
			end
		end else if (cnt_q == 16'd1) begin
			code_d = word.data_byte;
		end else if (cnt_q == 16'd2) begin
			mid_d[15:8] = word.data_byte;
		end else if (cnt_q == 16'd3) begin
			mid_d[7:0] = word.data_byte;
		end else if (cnt_q < hdr_end) begin
			if (tok_idx < TOK_MAX_LEN) begin
				tok_d[{tok_idx[2:0], 3'b000} +: 8] = word.data_byte;
			end
		end else if (!mark_q && (word.data_byte == PAYLOAD_MARKER)) begin
			mark_d   = 1'b1;
			pstart_d = cnt_q + 16'd1;
		end

		if (cnt_q == 16'hFFFF) begin
			bad_d = 1'b1;
		end else begin
			cnt_d = cnt_q + 16'd1;
		end
	end

	// Result for a datagram ending on this byte
	always_comb begin
		need_len = {12'd0, tlen_d} + HDR_LEN;
		plen     = 16'd0;
		ok       = (cnt_d >= HDR_LEN) && !bad_d && (cnt_d >= need_len);
		if (ok && mark_d) begin
			if (cnt_d > pstart_d) begin
				plen = cnt_d - pstart_d;
			end else begin
				ok = 1'b0;
			end
		end

		res = '0;
		if (ok) begin
			res.ok          = 1'b1;
			res.msg_type    = type_d;
			res.code        = code_d;
			res.msg_id      = mid_d;
			res.token_count = tlen_d;
			res.token_bytes = tok_d;
			if (mark_d) begin
				res.payload_found  = 1'b1;
				res.payload_offset = pstart_d;
				res.payload_length = plen;
			end
		end
	end

	// State: advance per byte, clear at end of datagram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			type_q   <= '0;
			code_q   <= '0;
			mid_q    <= '0;
			tlen_q   <= '0;
			tok_q    <= '0;
			mark_q   <= 1'b0;
			pstart_q <= '0;
			bad_q    <= 1'b0;
		end else if (step) begin
			if (word.last_byte) begin
				cnt_q    <= '0;
				type_q   <= '0;
				code_q   <= '0;
				mid_q    <= '0;
				tlen_q   <= '0;
				tok_q    <= '0;
				mark_q   <= 1'b0;
				pstart_q <= '0;
				bad_q    <= 1'b0;
			end else begin
				cnt_q    <= cnt_d;
				type_q   <= type_d;
				code_q   <= code_d;
				mid_q    <= mid_d;
				tlen_q   <= tlen_d;
				tok_q    <= tok_d;
				mark_q   <= mark_d;
				pstart_q <= pstart_d;
				bad_q    <= bad_d;
			end
		end
	end

endmodule

// ===== rtl/coap_header_parser_core.sv =====
// CoAP datagram header parser: top level with input and result registers.
// Takes one datagram byte per cycle, last byte flagged, and returns one result word
// per datagram: header fields, token (first byte in bits 7:0) and the location of
// the payload after the first 0xFF marker past the token. ok is low, with all
// other fields zero, for a short datagram, wrong version, oversized token, marker
// with nothing after it, or more than 65535 bytes. The parser sustains one byte
// every cycle unless a last byte is held; the combinational capture, count and
// compare logic between input and result registers sets that figure. A result is
// registered as its last byte leaves the input register. A held result word stalls
// input only when the next last byte waits in the input register.
`timescale 1ns / 1ps
`include "coap_header_parser_core_defines.svh"
module coap_header_parser_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  coap_hdr_pkg::coap_in_t  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output coap_hdr_pkg::coap_out_t out_data
);
	import coap_hdr_pkg::*;

	logic      valid_s1;
	coap_in_t  word_s1;
	logic      out_free;
	logic      adv;
	coap_out_t res;
	logic      out_valid_q;
	coap_out_t out_data_q;

	// Handshake: a non-last byte always advances; a last byte needs a free result slot
	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && (!word_s1.last_byte || out_free);
	assign in_ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	// Header tracking state
	coap_hdr_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.word   (word_s1),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && word_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && word_s1.last_byte) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks
	`COAP_ASSERT_NEXT(a_last_gives_result, clk, arst_n,
		adv && word_s1.last_byte, out_valid_q)
	`COAP_ASSERT_NOW(a_bad_is_zero, clk, arst_n,
		out_valid_q && !out_data_q.ok, out_data_q == '0)
	`COAP_ASSERT_NOW(a_tok_bound, clk, arst_n, out_valid_q && out_data_q.ok,
		({12'd0, out_data_q.token_count} <= TOK_MAX_LEN))
	`COAP_ASSERT_NOW(a_payload_pos, clk, arst_n, out_valid_q && out_data_q.payload_found,
		(out_data_q.payload_offset > HDR_LEN) && (out_data_q.payload_length != 16'd0))

endmodule
